@@ src/assert_macros.svh @@
// Assertion macros shared by the PID filter RTL.
// Included by every module that carries concurrent checks; needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// check gated off while reset is active
`define TSPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check that also holds through reset
`define TSPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TSPF_ASSERT(label, prop, msg)
`define TSPF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ src/tspf_pkg.sv @@
// Shared types and constants for the transport stream PID filter.
// No dependencies; used by tspf_out_fifo and ts_pid_filter_core.
package tspf_pkg;

    // PID space and header decoding
    localparam int          PID_W       = 13;
    localparam int          PID_COUNT   = 8192;
    localparam logic [7:0]  SYNC_BYTE   = 8'h47;
    localparam logic [7:0]  PID_HI_MASK = 8'h1f;

    // most results one stream byte can give (sync, header 1, header 2)
    localparam int          MAX_PUSH    = 3;
    localparam int          PUSH_W      = 2;

    // output queue depth; input held off once the queue could overflow
    localparam int          OUT_DEPTH   = 16;
    localparam int          STALL_LIMIT = OUT_DEPTH - 2 * MAX_PUSH;

    // one result transaction
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_item_t;

endpackage

@@ src/tspf_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are not reset.
module tspf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered on rd_en
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/tspf_out_fifo.sv @@
// Output queue of the PID filter: takes up to three results a cycle, gives one when not stalled.
// Depends on tspf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tspf_out_fifo #(
    parameter int DEPTH = 16
) (
    input  logic                                               clk,
    input  logic                                               rst_n,
    input  logic [tspf_pkg::PUSH_W-1:0]                        push_cnt,
    input  tspf_pkg::out_item_t [tspf_pkg::MAX_PUSH-1:0]       push_data,
    output logic [$clog2(DEPTH+1)-1:0]                         count,
    output logic                                               out_valid,
    input  logic                                               out_stall,
    output tspf_pkg::out_item_t                                out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    tspf_pkg::out_item_t entries_reg [DEPTH];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       wr_ptr_next;
    logic [AW-1:0]       rd_ptr_reg;
    logic [AW-1:0]       rd_ptr_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                pop;

    // head of queue and pop handshake
    assign out_valid = (count_reg != '0);
    assign out_item  = entries_reg[rd_ptr_reg];
    assign pop       = out_valid & ~out_stall;
    assign count     = count_reg;

    // pointer and fill arithmetic
    assign wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
    assign rd_ptr_next = rd_ptr_reg + AW'(pop);
    assign count_next  = count_reg + CW'(push_cnt) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, written at consecutive slots from the write pointer
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < tspf_pkg::MAX_PUSH; i++)
        begin
            if (i < int'(push_cnt))
            begin
                entries_reg[wr_ptr_reg + AW'(i)] <= push_data[i];
            end
        end
    end

    `TSPF_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(DEPTH), "output queue count above depth")
    `TSPF_ASSERT(a_no_overflow, (CW'(push_cnt) + count_reg) <= CW'(DEPTH), "output queue overflow")
    `TSPF_ASSERT(a_empty_ptrs, (count_reg != '0) || (wr_ptr_reg == rd_ptr_reg), "pointers apart when empty")

endmodule

@@ src/ts_pid_filter_core.sv @@
// Transport stream PID filter, one transaction per cycle on both channels when not stalled.
// A stream byte is taken into the decision stage register; its results then go to the output
// queue and are offered from there. Throughput: one item per cycle; input is held off while the
// queue lacks room for two more items' results or the RAM is being cleared. Reset: asynchronous;
// the PID enable RAM is then cleared one entry a cycle; config writes are taken throughout.
// Depends on tspf_pkg, tspf_ram, tspf_out_fifo and assert_macros.svh.
`include "assert_macros.svh"

module ts_pid_filter_core #(
    parameter int PACKET_BYTES = 188
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic                       pid_filter_on,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       action,
    input  logic [7:0]                 stream_byte,
    input  logic [tspf_pkg::PID_W-1:0] table_pid,
    input  logic                       table_enable,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [7:0]                 out_byte,
    output logic                       packet_end
);

    localparam int               POS_W    = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(PACKET_BYTES - 1);
    localparam int               PID_W    = tspf_pkg::PID_W;
    localparam int               CW       = $clog2(tspf_pkg::OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        MODE_UNDECIDED = 3'b001,
        MODE_FORWARD   = 3'b010,
        MODE_DISCARD   = 3'b100
    } mode_t;

    // accept stage
    logic               accept;
    logic               byte_acc;
    logic               tbl_acc;
    logic               pos_first;
    logic               pos_hdr1;
    logic               pos_hdr2;
    logic               pos_last;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [7:0]         hdr0_reg;
    logic               filter_on_reg;

    // RAM clearing pass
    logic [PID_W:0]     clr_cnt_reg;
    logic               clr_done;

    // RAM ports
    logic               ram_wr_en;
    logic [PID_W-1:0]   ram_wr_addr;
    logic               ram_wr_data;
    logic               ram_rd_en;
    logic [PID_W-1:0]   ram_rd_addr;
    logic               ram_rd_data;

    // decision stage
    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_first_reg;
    logic               s1_hdr2_reg;
    logic               s1_last_reg;
    mode_t              mode_reg;
    mode_t              mode_next;
    logic [tspf_pkg::PUSH_W-1:0]                  push_cnt;
    tspf_pkg::out_item_t [tspf_pkg::MAX_PUSH-1:0] push_data;

    // output queue
    logic [CW-1:0]       fifo_count;
    tspf_pkg::out_item_t head_item;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_on_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            filter_on_reg <= pid_filter_on;
        end
    end

    // input handshake
    assign clr_done = clr_cnt_reg[PID_W];
    assign in_stall = ~clr_done | (fifo_count > CW'(tspf_pkg::STALL_LIMIT));
    assign accept   = in_valid & ~in_stall;
    assign byte_acc = accept & ~action;
    assign tbl_acc  = accept & action;

    // slot position
    assign pos_first = (pos_reg == '0);
    assign pos_hdr1  = (pos_reg == POS_W'(1));
    assign pos_hdr2  = (pos_reg == POS_W'(2));
    assign pos_last  = (pos_reg >= LAST_POS);
    assign pos_next  = pos_last ? '0 : pos_reg + POS_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (byte_acc)
        begin
            pos_reg <= pos_next;
        end
    end

    // header byte 1 held until the PID is complete
    always_ff @(posedge clk)
    begin
        if (byte_acc && pos_hdr1)
        begin
            hdr0_reg <= stream_byte;
        end
    end

    // clearing pass over the enable map after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (!clr_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + (PID_W + 1)'(1);
        end
    end

    // enable map: table writes or clearing, lookup on header byte 2
    assign ram_wr_en   = ~clr_done | tbl_acc;
    assign ram_wr_addr = clr_done ? table_pid : clr_cnt_reg[PID_W-1:0];
    assign ram_wr_data = clr_done & table_enable;
    assign ram_rd_en   = byte_acc & pos_hdr2;
    assign ram_rd_addr = PID_W'({hdr0_reg & tspf_pkg::PID_HI_MASK, stream_byte});

    tspf_ram #(
        .WIDTH (1),
        .DEPTH (tspf_pkg::PID_COUNT)
    ) u_pid_map (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // stage register, lines up with the RAM read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= byte_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_acc)
        begin
            s1_byte_reg  <= stream_byte;
            s1_first_reg <= pos_first;
            s1_hdr2_reg  <= pos_hdr2;
            s1_last_reg  <= pos_last;
        end
    end

    // packet decision and result generation
    always_comb
    begin
        mode_next = mode_reg;
        push_cnt  = '0;
        push_data = '0;
        if (s1_valid_reg)
        begin
            if (s1_first_reg)
            begin
                mode_next = (s1_byte_reg == tspf_pkg::SYNC_BYTE) ? MODE_UNDECIDED
                                                                 : MODE_DISCARD;
            end
            else
            begin
                case (mode_reg)
                    MODE_UNDECIDED:
                    begin
                        if (s1_hdr2_reg)
                        begin
                            if (!filter_on_reg || ram_rd_data)
                            begin
                                mode_next         = MODE_FORWARD;
                                push_cnt          = tspf_pkg::PUSH_W'(tspf_pkg::MAX_PUSH);
                                push_data[0].data = tspf_pkg::SYNC_BYTE;
                                push_data[0].last = 1'b0;
                                push_data[1].data = hdr0_reg;
                                push_data[1].last = 1'b0;
                                push_data[2].data = s1_byte_reg;
                                push_data[2].last = s1_last_reg;
                            end
                            else
                            begin
                                mode_next = MODE_DISCARD;
                            end
                        end
                    end
                    MODE_FORWARD:
                    begin
                        push_cnt          = tspf_pkg::PUSH_W'(1);
                        push_data[0].data = s1_byte_reg;
                        push_data[0].last = s1_last_reg;
                    end
                    MODE_DISCARD:
                    begin
                        mode_next = MODE_DISCARD;
                    end
                    default:
                    begin
                        mode_next = MODE_DISCARD;
                    end
                endcase
            end
            // end of slot: next slot starts undecided
            if (s1_last_reg)
            begin
                mode_next = MODE_UNDECIDED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_UNDECIDED;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // result queue
    tspf_out_fifo #(
        .DEPTH (tspf_pkg::OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_cnt  (push_cnt),
        .push_data (push_data),
        .count     (fifo_count),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (head_item)
    );

    assign out_byte   = head_item.data;
    assign packet_end = head_item.last;

    `TSPF_ASSERT(a_decided, (s1_valid_reg && s1_hdr2_reg && !s1_first_reg && !s1_last_reg && (mode_reg == MODE_UNDECIDED)) |=> ((mode_reg == MODE_FORWARD) || (mode_reg == MODE_DISCARD)), "no pass decision on header byte 2")
    `TSPF_ASSERT(a_discard_quiet, (s1_valid_reg && !s1_first_reg && (mode_reg == MODE_DISCARD)) |-> (push_cnt == '0), "result from a discarded slot")
    `TSPF_ASSERT(a_clear_no_table, !clr_done |-> !ram_rd_en, "lookup during clearing pass")

endmodule
